// ===== rtl/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

    localparam int MAT_ELEMS = 12;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_APPLY = 2'd2;
    localparam logic [1:0] OP_SKIP  = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic               last;
        logic [5:0]         bone;
        logic [3:0]         elem;
        logic signed [31:0] value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        w;
    } lbs_item_t;

    typedef struct packed {
        logic clearing;
    } lbs_status_t;

endpackage
`default_nettype wire

// ===== rtl/lbs_front.sv =====
`default_nettype none
module lbs_front #(
    parameter int BONE_COUNT = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // bone_index, element_index, matrix_value, pos_x, pos_y, pos_z,
    // influence_weight, influence_absent
    input  wire logic [159:0]       s_tdata,
    // kind
    input  wire logic               s_tuser,
    input  wire logic               s_tlast,
    input  wire lbs_pkg::lbs_status_t status,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output lbs_pkg::lbs_item_t      q_item
);
    import lbs_pkg::*;

    localparam logic [8:0] BONE_LIM = 9'(BONE_COUNT);

    lbs_item_t  fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    lbs_item_t  item;
    logic       push, pop, bone_ok, elem_ok;
    logic [16:0] w_in;

    assign bone_ok = {3'b000, s_tdata[5:0]} < BONE_LIM;
    assign elem_ok = s_tdata[9:6] < 4'(MAT_ELEMS);
    assign w_in    = s_tdata[154:138];

    always_comb begin
        item       = '0;
        item.bone  = s_tdata[5:0];
        item.elem  = s_tdata[9:6];
        item.value = s_tdata[41:10];
        item.x     = s_tdata[73:42];
        item.y     = s_tdata[105:74];
        item.z     = s_tdata[137:106];
        item.w     = (w_in > ONE_Q16) ? ONE_Q16 : w_in;
        if (!s_tuser) begin
            item.op   = (bone_ok && elem_ok) ? OP_LOAD : OP_NOP;
            item.last = 1'b0;
        end else begin
            item.op   = (bone_ok && !s_tdata[155]) ? OP_APPLY : OP_SKIP;
            item.last = s_tlast;
        end
    end

    assign s_tready = (count_reg != 2'd2) && !status.clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = count_reg != 2'd0;
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && !pop) |=> !s_tready)
        else $error("queue accepted past full");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count lost a push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !q_valid)
        else $error("empty queue shows an item");

endmodule
`default_nettype wire

// ===== rtl/lbs_back.sv =====
`default_nettype none
module lbs_back #(
    parameter int BONE_COUNT = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire lbs_pkg::lbs_item_t  q_item,
    output lbs_pkg::lbs_status_t     status,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [103:0]             m_tdata
);
    import lbs_pkg::*;

    localparam int DEPTH  = BONE_COUNT * MAT_ELEMS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    logic [1:0]  state_reg, state_next;
    logic        clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [3:0]  k_reg, k_next;
    logic [11:0] base_reg, base_next;
    logic        last_reg, last_next;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [16:0] w_reg;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [3:0]  s1_k_reg, s2_k_reg;
    logic [1:0]  s3_row_reg, s4_row_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [49:0] t_reg, t_next;
    logic signed [67:0] wprod_reg;

    logic signed [47:0] sum_reg [3];
    logic signed [51:0] c_wide;
    logic signed [47:0] c_sat;
    logic signed [48:0] acc;
    logic signed [47:0] acc_sat;

    logic        pop, emit_go, wr_en, issue;
    logic [11:0] load_addr;
    logic signed [31:0] coord;
    logic [31:0] out_c [3];
    logic [2:0]  clamp_hit;
    logic [103:0] m_tdata_reg;
    logic        m_tvalid_reg;

    assign status.clearing = clearing_reg;
    assign q_ready = (state_reg == ST_IDLE) && !clearing_reg;
    assign pop     = q_valid && q_ready;
    assign emit_go = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign issue   = state_reg == ST_ISSUE;
    assign wr_en   = pop && (q_item.op == OP_LOAD);
    assign load_addr = ({3'b000, q_item.bone, 3'b000} + {4'b0000, q_item.bone, 2'b00})
                     + {8'd0, q_item.elem};

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    last_next = q_item.last;
                    base_next = {3'b000, q_item.bone, 3'b000} + {4'b0000, q_item.bone, 2'b00};
                    k_next    = 4'd0;
                    if (q_item.op == OP_APPLY) begin
                        state_next = ST_ISSUE;
                    end else if (q_item.op == OP_SKIP && q_item.last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ISSUE: begin
                k_next = k_reg + 4'd1;
                if (k_reg == 4'(MAT_ELEMS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (s4_valid_reg && s4_row_reg == 2'd2) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            sum_reg[0]   <= '0;
            sum_reg[1]   <= '0;
            sum_reg[2]   <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && (s2_k_reg[1:0] == 2'd3);
            s4_valid_reg <= s3_valid_reg;
            if (emit_go) begin
                m_tvalid_reg <= 1'b1;
                sum_reg[0]   <= '0;
                sum_reg[1]   <= '0;
                sum_reg[2]   <= '0;
            end else begin
                if (m_tready) begin
                    m_tvalid_reg <= 1'b0;
                end
                if (s4_valid_reg) begin
                    sum_reg[s4_row_reg] <= acc_sat;
                end
            end
        end
    end

    // matrix store
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[ADDR_W'(load_addr)] <= q_item.value;
        end
        rd_data_reg <= mem[ADDR_W'(base_reg + {8'd0, k_reg})];
    end

    always_comb begin
        case (s1_k_reg[1:0])
            2'd0:    coord = x_reg;
            2'd1:    coord = y_reg;
            default: coord = z_reg;
        endcase
        if (s1_k_reg[1:0] == 2'd3) begin
            prod_next = {{16{rd_data_reg[31]}}, rd_data_reg, 16'h0000};
        end else begin
            prod_next = $signed(rd_data_reg) * coord;
        end
        t_next = ((s2_k_reg[1:0] == 2'd0) ? 50'sd0 : t_reg)
               + 50'($signed(prod_reg[63:16]));
    end

    always_comb begin
        c_wide = wprod_reg[67:16];
        if (c_wide[51:47] == 5'b00000 || c_wide[51:47] == 5'b11111) begin
            c_sat = c_wide[47:0];
        end else begin
            c_sat = c_wide[51] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        acc = {sum_reg[s4_row_reg][47], sum_reg[s4_row_reg]} + {c_sat[47], c_sat};
        if (acc[48] == acc[47]) begin
            acc_sat = acc[47:0];
        end else begin
            acc_sat = acc[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        base_reg <= base_next;
        last_reg <= last_next;
        if (pop) begin
            x_reg <= q_item.x;
            y_reg <= q_item.y;
            z_reg <= q_item.z;
            w_reg <= q_item.w;
        end
        s1_k_reg   <= k_reg;
        s2_k_reg   <= s1_k_reg;
        prod_reg   <= prod_next;
        if (s2_valid_reg) begin
            t_reg <= t_next;
        end
        s3_row_reg <= s2_k_reg[3:2];
        s4_row_reg <= s3_row_reg;
        wprod_reg  <= t_reg * $signed({1'b0, w_reg});
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (sum_reg[i][47:31] == 17'h00000 || sum_reg[i][47:31] == 17'h1ffff) begin
                out_c[i]     = sum_reg[i][31:0];
                clamp_hit[i] = 1'b0;
            end else begin
                out_c[i]     = sum_reg[i][47] ? 32'h80000000 : 32'h7fffffff;
                clamp_hit[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_tdata_reg <= {7'd0, |clamp_hit, out_c[2], out_c[1], out_c[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("row result outside an influence");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_row_reg != 2'd3))
        else $error("bad matrix row");
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go |=> (m_tvalid_reg && sum_reg[0] == 48'sd0 && sum_reg[2] == 48'sd0))
        else $error("emit did not clear sums");
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !pop)
        else $error("request taken during store clear");

endmodule
`default_nettype wire

// ===== rtl/linear_blend_skinning.sv =====
// load or skipped influence: taken in ST_IDLE, a skipped one ending a vertex also
// passes ST_EMIT. applied influence: ST_ISSUE reads the 12 matrix elements through
// one matrix-store read port, rotation terms via a shared multiplier, then ST_DRAIN,
// and ST_EMIT when it ends a vertex; a held output adds its stall. items are taken
// only in ST_IDLE; a 2-entry queue and an output register decouple input and output
// stalls; after reset all BONE_COUNT*12 store entries are cleared, s_tready low
`default_nettype none
module linear_blend_skinning #(
    parameter int BONE_COUNT = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // bone_index, element_index, matrix_value, pos_x, pos_y, pos_z,
    // influence_weight, influence_absent
    input  wire logic [159:0] s_tdata,
    // kind
    input  wire logic         s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x, out_y, out_z, saturated
    output logic [103:0]      m_tdata
);
    import lbs_pkg::*;

    logic        q_valid, q_ready;
    lbs_item_t   q_item;
    lbs_status_t status;

    lbs_front #(.BONE_COUNT(BONE_COUNT)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .status  (status),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    lbs_back #(.BONE_COUNT(BONE_COUNT)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire

// ===== dv/linear_blend_skinning_tb.sv =====
`default_nettype none
module linear_blend_skinning_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BONES = 64;
    localparam int ELEMS = 12;
    localparam int RAND_ITEMS = 1500;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_INFLUENCE = 1'b1;
    localparam longint S48_MAX = 64'sh00007FFFFFFFFFFF;
    localparam longint S48_MIN = -S48_MAX - 1;
    localparam longint S32_MAX = 64'sh000000007FFFFFFF;
    localparam longint S32_MIN = -S32_MAX - 1;

    typedef struct {
        logic        kind;
        logic [5:0]  bone;
        logic [3:0]  elem;
        logic [31:0] value;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [16:0] w;
        logic        absent;
        logic        last;
    } request_t;

    typedef struct {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic        sat;
    } vertex_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [159:0] s_tdata;
    logic s_tuser;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [103:0] m_tdata;

    linear_blend_skinning #(.BONE_COUNT(BONES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    request_t pending_requests[$];
    vertex_t expected_vertices[$];
    logic [31:0] bone_matrix[BONES*ELEMS];
    longint acc_x, acc_y, acc_z;
    int errors = 0;
    int vertices_seen = 0;
    int requests_sent = 0;
    int send_idle = 0;
    int recv_idle = 0;
    longint cycles = 0;
    bit calm = 0;
    bit hold_long = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    task automatic queue_request(request_t r);
        pending_requests.insert(pending_requests.size(), r);
    endtask

    function automatic longint floor_q16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint bone_row(int base, longint x, longint y, longint z, longint w);
        longint m0, m1, m2, m3, t, hi, lo;
        m0 = longint'($signed(bone_matrix[base]));
        m1 = longint'($signed(bone_matrix[base+1]));
        m2 = longint'($signed(bone_matrix[base+2]));
        m3 = longint'($signed(bone_matrix[base+3]));
        t = floor_q16(m0 * x) + floor_q16(m1 * y) + floor_q16(m2 * z) + m3;
        hi = floor_q16(t);
        lo = t - hi * 65536;
        return clamp(hi * w + ((lo * w) >>> 16), S48_MIN, S48_MAX);
    endfunction

    task automatic skin_request(request_t r);
        longint w, x, y, z;
        int base;
        vertex_t v;
        if (r.kind == KIND_LOAD) begin
            if (r.bone < BONES && r.elem < ELEMS) bone_matrix[r.bone*ELEMS + r.elem] = r.value;
            return;
        end
        w = (r.w > 17'h10000) ? 65536 : longint'(r.w);
        if (!r.absent && r.bone < BONES) begin
            x = longint'($signed(r.x));
            y = longint'($signed(r.y));
            z = longint'($signed(r.z));
            base = r.bone * ELEMS;
            acc_x = clamp(acc_x + bone_row(base, x, y, z, w), S48_MIN, S48_MAX);
            acc_y = clamp(acc_y + bone_row(base + 4, x, y, z, w), S48_MIN, S48_MAX);
            acc_z = clamp(acc_z + bone_row(base + 8, x, y, z, w), S48_MIN, S48_MAX);
        end
        if (!r.last) return;
        v.ox = 32'(clamp(acc_x, S32_MIN, S32_MAX));
        v.oy = 32'(clamp(acc_y, S32_MIN, S32_MAX));
        v.oz = 32'(clamp(acc_z, S32_MIN, S32_MAX));
        v.sat = (acc_x != clamp(acc_x, S32_MIN, S32_MAX)) ||
                (acc_y != clamp(acc_y, S32_MIN, S32_MAX)) ||
                (acc_z != clamp(acc_z, S32_MIN, S32_MAX));
        expected_vertices.insert(expected_vertices.size(), v);
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic request_t make_load(int bone, int elem, logic [31:0] value);
        request_t r;
        r.kind = KIND_LOAD;
        r.bone = 6'(bone);
        r.elem = 4'(elem);
        r.value = value;
        r.x = $urandom;
        r.y = $urandom;
        r.z = $urandom;
        r.w = 17'($urandom);
        r.absent = 1'($urandom);
        r.last = 1'($urandom);
        return r;
    endfunction

    function automatic request_t make_influence(int bone, logic [16:0] w, bit absent, bit last);
        request_t r;
        r.kind = KIND_INFLUENCE;
        r.bone = 6'(bone);
        r.elem = 4'($urandom);
        r.value = $urandom;
        r.x = rand_coord();
        r.y = rand_coord();
        r.z = rand_coord();
        r.w = w;
        r.absent = absent;
        r.last = last;
        return r;
    endfunction

    function automatic logic [31:0] rand_matrix_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
            s_tuser <= 0;
            s_tlast <= 0;
        end else begin
            request_t r;
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) requests_sent++;
                if (!calm && send_idle > 0) begin
                    send_idle--;
                    s_tvalid <= 0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_idle = $urandom_range(0, 7);
                    s_tvalid <= 0;
                end else if (pending_requests.size() > 0) begin
                    r = pending_requests.pop_front();
                    skin_request(r);
                    s_tvalid <= 1;
                    s_tuser <= r.kind;
                    s_tlast <= r.last;
                    s_tdata <= {4'b0, r.absent, r.w, r.z, r.y, r.x, r.value, r.elem, r.bone};
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_long) begin
            m_tready <= 0;
        end else if (!calm && recv_idle > 0) begin
            recv_idle--;
            m_tready <= 0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_idle = $urandom_range(0, 7);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            vertex_t e;
            vertices_seen++;
            if (expected_vertices.size() == 0) begin
                errors++;
                $display("unexpected vertex result %h", m_tdata);
            end else begin
                e = expected_vertices.pop_front();
                if (m_tdata[31:0] !== e.ox) report("out_x", m_tdata[31:0], e.ox);
                if (m_tdata[63:32] !== e.oy) report("out_y", m_tdata[63:32], e.oy);
                if (m_tdata[95:64] !== e.oz) report("out_z", m_tdata[95:64], e.oz);
                if (m_tdata[96] !== e.sat) report("saturated", 32'(m_tdata[96]), 32'(e.sat));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int n, k, b, nslots;
        foreach (bone_matrix[i]) bone_matrix[i] = '0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        aresetn = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // directed: unloaded bone, identity bone, extremes, ignored loads, weight clamp
        queue_request(make_influence(5, 17'h10000, 0, 1));
        for (int e = 0; e < ELEMS; e++)
            queue_request(make_load(1, e, (e % 5 == 0) ? 32'h00010000 : 32'h0));
        queue_request(make_load(1, 12, 32'h12345678));
        queue_request(make_load(1, 15, 32'hFFFFFFFF));
        queue_request(make_influence(1, 17'h1FFFF, 0, 0));
        queue_request(make_influence(1, 17'h08000, 0, 0));
        queue_request(make_influence(1, 17'h0, 1, 0));
        queue_request(make_influence(63, 17'h0, 0, 1));
        queue_request(make_load(2, 0, 32'h7FFFFFFF));
        queue_request(make_load(2, 3, 32'h7FFFFFFF));
        queue_request(make_load(2, 11, 32'h80000000));
        for (int i = 0; i < 4; i++)
            queue_request(make_influence(2, 17'h10000, 0, i == 3));
        queue_request(make_influence(0, 17'h10000, 1, 1));

        // random: mostly well-formed vertices over a few loaded bones, some noise
        n = 0;
        while (n < RAND_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(1, 12);
                for (int i = 0; i < k; i++) begin
                    b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
                    queue_request(make_load(b,
                        ($urandom_range(0, 15) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11),
                        rand_matrix_value()));
                end
                n += k;
            end else begin
                nslots = $urandom_range(1, 6);
                for (int i = 0; i < nslots; i++) begin
                    b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
                    queue_request(make_influence(b,
                        ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                        $urandom_range(0, 5) == 0, i == nslots - 1));
                end
                n += nslots;
            end
            if (n > 200 && n < 230 && !hold_long) begin
                wait (pending_requests.size() < 20);
            end
        end

        // long receiver hold-off while requests keep coming
        wait (pending_requests.size() < RAND_ITEMS / 2);
        hold_long = 1;
        repeat (400) @(posedge aclk);
        hold_long = 0;

        wait (pending_requests.size() < 100);
        calm = 1;
        wait (pending_requests.size() == 0 && !s_tvalid);
        wait (expected_vertices.size() == 0);
        repeat (50) @(posedge aclk);

        $display("sent %0d requests, checked %0d skinned vertices", requests_sent, vertices_seen);
        $display("covered matrix loads, skipped and out-of-range slots, weight clamp, saturation");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
